>>> rtl/efr_pkg.sv
// Shared types and constants for the event frame receiver.
// Holds the item structs, the parser phase enum and the field codes.
// No dependencies.
package efr_pkg;

	localparam logic [7:0] SYNC_BYTE   = 8'hAA;
	localparam logic [7:0] SECOND_BYTE = 8'h00;

	// Configuration register indexes.
	localparam logic CFG_ACK_CODE  = 1'b0;
	localparam logic CFG_CALL_CODE = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [7:0] ACK_CODE_RST  = 8'd0;
	localparam logic [7:0] CALL_CODE_RST = 8'd2;

	// Result kinds.
	localparam logic [1:0] KIND_PARAM     = 2'd0;
	localparam logic [1:0] KIND_FRAME_END = 2'd1;
	localparam logic [1:0] KIND_QUERY     = 2'd2;

	// Frame status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_BAD_CSUM = 2'd1;
	localparam logic [1:0] STAT_ZERO_LEN = 2'd2;

	// Depth of the result buffer.
	localparam int OUT_DEPTH = 2;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_ZERO,
		PH_LEN,
		PH_CODE,
		PH_PARAM,
		PH_CSUM
	} phase_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
		logic [7:0] query_opcode;
	} in_item_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [7:0] evt_code;
		logic [7:0] param_index;
		logic [7:0] param_byte;
		logic [1:0] frame_status;
		logic       needs_ack;
		logic [7:0] call_status;
		logic       ack_match;
	} out_item_t;

	typedef struct packed {
		logic [7:0] ack_code;
		logic [7:0] call_code;
	} cfg_regs_t;

endpackage

>>> rtl/efr_parser.sv
// Frame parser: phase register, checksum, stored ACK and call status.
// Turns one registered input item into at most one result per cycle.
// Depends on efr_pkg.
module efr_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  efr_pkg::in_item_t    item_s1,
	input  efr_pkg::cfg_regs_t   cfg,
	output logic                 res_valid,
	output efr_pkg::out_item_t   res
);

	efr_pkg::phase_t phase_q, phase_d;
	logic [7:0] frame_len_q, frame_len_d;
	logic [7:0] param_cnt_q, param_cnt_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] event_q, event_d;
	logic [7:0] first_q, first_d;
	logic [7:0] second_q, second_d;
	logic [7:0] acked_op_q, acked_op_d;
	logic       acked_vld_q, acked_vld_d;
	logic [7:0] call_stat_q, call_stat_d;

	logic [7:0] b;
	logic [7:0] sum_add;
	logic [7:0] cnt_inc;
	logic [8:0] cnt_cmp;
	logic       good;
	logic       match;

	assign b       = item_s1.rx_byte;
	assign sum_add = sum_q + b;
	assign cnt_inc = param_cnt_q + 8'd1;
	assign cnt_cmp = {1'b0, cnt_inc} + 9'd1;
	assign good    = (sum_add == 8'd0);
	assign match   = acked_vld_q && (acked_op_q == item_s1.query_opcode);

	// Next state of the parser and the stored event state.
	always_comb begin
		phase_d     = phase_q;
		frame_len_d = frame_len_q;
		param_cnt_d = param_cnt_q;
		sum_d       = sum_q;
		event_d     = event_q;
		first_d     = first_q;
		second_d    = second_q;
		acked_op_d  = acked_op_q;
		acked_vld_d = acked_vld_q;
		call_stat_d = call_stat_q;

		if (adv) begin
			if (item_s1.cmd) begin
				// A query leaves any frame in progress alone.
				if (match) begin
					acked_vld_d = 1'b0;
				end
			end else begin
				unique case (phase_q)
					efr_pkg::PH_HUNT: begin
						if (b == efr_pkg::SYNC_BYTE) begin
							phase_d = efr_pkg::PH_ZERO;
						end
					end
					efr_pkg::PH_ZERO: begin
						phase_d = (b == efr_pkg::SECOND_BYTE) ? efr_pkg::PH_LEN
							: efr_pkg::PH_HUNT;
					end
					efr_pkg::PH_LEN: begin
						frame_len_d = b;
						if (b == 8'd0) begin
							phase_d = efr_pkg::PH_HUNT;
						end else begin
							sum_d   = b;
							phase_d = efr_pkg::PH_CODE;
						end
					end
					efr_pkg::PH_CODE: begin
						event_d     = b;
						sum_d       = sum_add;
						param_cnt_d = 8'd0;
						first_d     = 8'd0;
						second_d    = 8'd0;
						phase_d     = (frame_len_q == 8'd1) ? efr_pkg::PH_CSUM
							: efr_pkg::PH_PARAM;
					end
					efr_pkg::PH_PARAM: begin
						if (param_cnt_q == 8'd0) begin
							first_d = b;
						end
						if (param_cnt_q == 8'd1) begin
							second_d = b;
						end
						sum_d       = sum_add;
						param_cnt_d = cnt_inc;
						if (cnt_cmp >= {1'b0, frame_len_q}) begin
							phase_d = efr_pkg::PH_CSUM;
						end
					end
					efr_pkg::PH_CSUM: begin
						sum_d = sum_add;
						// A code that matches both registers counts as an ACK only.
						if (good) begin
							priority if (event_q == cfg.ack_code) begin
								if (param_cnt_q != 8'd0) begin
									acked_op_d  = first_q;
									acked_vld_d = 1'b1;
								end
							end else if (event_q == cfg.call_code &&
								param_cnt_q >= 8'd2) begin
								call_stat_d = second_q;
							end
						end
						phase_d = efr_pkg::PH_HUNT;
					end
					default: begin
						phase_d = efr_pkg::PH_HUNT;
					end
				endcase
			end
		end
	end

	// Result of the registered item.
	always_comb begin
		res_valid = 1'b0;
		res       = '0;

		if (adv) begin
			if (item_s1.cmd) begin
				res_valid       = 1'b1;
				res.result_kind = efr_pkg::KIND_QUERY;
				res.ack_match   = match;
			end else begin
				unique case (phase_q)
					efr_pkg::PH_LEN: begin
						if (b == 8'd0) begin
							res_valid        = 1'b1;
							res.result_kind  = efr_pkg::KIND_FRAME_END;
							res.frame_status = efr_pkg::STAT_ZERO_LEN;
						end
					end
					efr_pkg::PH_PARAM: begin
						res_valid       = 1'b1;
						res.result_kind = efr_pkg::KIND_PARAM;
						res.evt_code    = event_q;
						res.param_index = param_cnt_q;
						res.param_byte  = b;
					end
					efr_pkg::PH_CSUM: begin
						res_valid        = 1'b1;
						res.result_kind  = efr_pkg::KIND_FRAME_END;
						res.evt_code     = event_q;
						res.param_index  = param_cnt_q;
						res.frame_status = good ? efr_pkg::STAT_OK : efr_pkg::STAT_BAD_CSUM;
						res.needs_ack    = good && (event_q != cfg.ack_code);
					end
					default: begin
					end
				endcase
			end
		end
		res.call_status = call_stat_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= efr_pkg::PH_HUNT;
			frame_len_q <= 8'd0;
			param_cnt_q <= 8'd0;
			sum_q       <= 8'd0;
			event_q     <= 8'd0;
			first_q     <= 8'd0;
			second_q    <= 8'd0;
			acked_op_q  <= 8'd0;
			acked_vld_q <= 1'b0;
			call_stat_q <= 8'd0;
		end else begin
			phase_q     <= phase_d;
			frame_len_q <= frame_len_d;
			param_cnt_q <= param_cnt_d;
			sum_q       <= sum_d;
			event_q     <= event_d;
			first_q     <= first_d;
			second_q    <= second_d;
			acked_op_q  <= acked_op_d;
			acked_vld_q <= acked_vld_d;
			call_stat_q <= call_stat_d;
		end
	end

endmodule

>>> rtl/efr_out_buf.sv
// Two-entry result buffer between the parser and the output channel.
// Lets the parser keep going while a result waits to be taken.
// Depends on efr_pkg.
module efr_out_buf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  efr_pkg::out_item_t   push_item,
	output logic                 can_push,
	output logic                 out_valid,
	input  logic                 out_stall,
	output efr_pkg::out_item_t   out_item
);

	localparam int PTR_W = $clog2(efr_pkg::OUT_DEPTH);
	localparam int CNT_W = $clog2(efr_pkg::OUT_DEPTH + 1);

	efr_pkg::out_item_t mem_q [efr_pkg::OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && !out_stall;
	// A slot freed by a pop in this cycle can be refilled in the same cycle.
	assign can_push  = (count_q != CNT_W'(efr_pkg::OUT_DEPTH)) || pop;
	assign out_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

>>> rtl/event_frame_receiver.sv
// Top level of the UART event frame receiver.
// Holds the configuration registers and the input register; uses efr_pkg,
// efr_parser and efr_out_buf.
//
//   channel   direction   handshake              payload
//   in        into block  in_valid / in_stall    in_item  (efr_pkg::in_item_t)
//   out       from block  out_valid / out_stall  out_item (efr_pkg::out_item_t)
//   cfg       into block  cfg_we                 cfg_index, cfg_data
//
// One item per cycle is accepted while the output keeps flowing.
// An item is registered in item_s1 and parsed from there once its result has a
// buffer slot; the result then passes through the result buffer to the output.
// Reset puts the parser in the hunt for the sync byte and empties the buffer.
// A stalled output holds up to two results before the input stalls.
module event_frame_receiver (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  efr_pkg::in_item_t    in_item,
	output logic                 out_valid,
	input  logic                 out_stall,
	output efr_pkg::out_item_t   out_item,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data
);

	efr_pkg::cfg_regs_t cfg_q;
	efr_pkg::in_item_t  item_s1;
	logic               valid_s1;
	logic               adv;
	logic               can_push;
	logic               res_valid;
	efr_pkg::out_item_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ack_code  <= efr_pkg::ACK_CODE_RST;
			cfg_q.call_code <= efr_pkg::CALL_CODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				efr_pkg::CFG_ACK_CODE:  cfg_q.ack_code  <= cfg_data;
				efr_pkg::CFG_CALL_CODE: cfg_q.call_code <= cfg_data;
				default:                cfg_q           <= cfg_q;
			endcase
		end
	end

	// The registered item moves on only when its result has a buffer slot.
	assign adv      = valid_s1 && can_push;
	assign in_stall = valid_s1 && !can_push;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_item;
		end
	end

	efr_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item_s1   (item_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	efr_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_item (res),
		.can_push  (can_push),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

>>> rtl/efr_checker.sv
// Port-level checks for the event frame receiver, bound to the top level.
// Depends on efr_pkg.
module efr_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input efr_pkg::out_item_t   out_item
);

	// A result that is not taken stays in place.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.result_kind == efr_pkg::KIND_PARAM ||
			out_item.result_kind == efr_pkg::KIND_FRAME_END ||
			out_item.result_kind == efr_pkg::KIND_QUERY))
		else $error("illegal result kind");

	// Only a frame with a good checksum can ask for an acknowledge.
	a_ack_good_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.needs_ack |->
			out_item.result_kind == efr_pkg::KIND_FRAME_END &&
			out_item.frame_status == efr_pkg::STAT_OK)
		else $error("acknowledge request on a bad frame");

	a_match_query_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.ack_match |->
			out_item.result_kind == efr_pkg::KIND_QUERY)
		else $error("match flag outside a query answer");

	a_zero_len_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.frame_status == efr_pkg::STAT_ZERO_LEN |->
			out_item.evt_code == 8'd0 && out_item.param_index == 8'd0)
		else $error("zero-length frame end carries frame data");

endmodule

bind event_frame_receiver efr_checker u_efr_checker (.*);
